// File: sv/tcb_pkg.sv
// Shared constants and control types for the transitive closure bitset unit.
`default_nettype none
package tcb_pkg;

  localparam int ROW_W = 64;
  localparam int IDX_W = 6;
  localparam int NC_W  = 7;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_CLOSE = 3'b010,
    ST_DRAIN = 3'b100
  } tcb_state_t;

  typedef struct packed {
    logic shift;
    logic close;
    logic load;
  } tcb_ctl_t;

endpackage
`default_nettype wire

// File: sv/tcb_cell.sv
// One row cell of the closure chain: shifts, or applies one pivot step.
`default_nettype none
module tcb_cell
  import tcb_pkg::*;
#(
  parameter int RW = 64,
  parameter int IW = 6
) (
  input  wire logic          clk,
  input  wire tcb_ctl_t      ctl,
  input  wire logic [IW-1:0] pivot_k,
  input  wire logic [RW-1:0] head_row,
  input  wire logic [RW-1:0] feed_row,
  output logic      [RW-1:0] row
);

  logic [RW-1:0] row_r;
  logic [RW-1:0] row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ctl.shift) begin
      row_nxt = feed_row;
    end else if (ctl.close) begin
      row_nxt = feed_row | (feed_row[pivot_k] ? head_row : '0);
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  assign row = row_r;

endmodule
`default_nettype wire

// File: sv/tcb_ctrl.sv
// Sequencer: row loading, pivot steps and draining of the closed rows.
`default_nettype none
module tcb_ctrl
  import tcb_pkg::*;
#(
  parameter int CW = 7,
  parameter int IW = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             cfg_we,
  input  wire logic [CW-1:0]    n_act,
  output logic                  busy,
  output tcb_ctl_t              ctl,
  output logic [IW-1:0]         pivot_k,
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_index,
  output logic                  out_last
);

  tcb_state_t       state_r, state_nxt;
  logic [CW-1:0]    loaded_r, loaded_nxt;
  logic [IW-1:0]    step_r, step_nxt;
  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] index_r, index_nxt;
  logic             last_r, last_nxt;
  logic             step_end;
  logic             accept;

  assign accept   = start && (state_r == ST_LOAD);
  assign step_end = (({1'b0, step_r} + {{IW{1'b0}}, 1'b1}) == (IW+1)'(n_act));

  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    step_nxt   = step_r;
    valid_nxt  = 1'b0;
    index_nxt  = index_r;
    last_nxt   = 1'b0;
    ctl        = '0;
    case (state_r)
      ST_LOAD: begin
        if (cfg_we) begin
          loaded_nxt = '0;
        end else if (accept) begin
          ctl.shift = 1'b1;
          ctl.load  = 1'b1;
          if (loaded_r + 1'b1 == n_act) begin
            loaded_nxt = '0;
            step_nxt   = '0;
            state_nxt  = ST_CLOSE;
          end else begin
            loaded_nxt = loaded_r + 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        ctl.close = 1'b1;
        if (step_end) begin
          step_nxt  = '0;
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        ctl.shift = 1'b1;
        valid_nxt = 1'b1;
        index_nxt = IDX_W'(step_r);
        last_nxt  = step_end;
        if (step_end) begin
          step_nxt  = '0;
          state_nxt = ST_LOAD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt  = ST_LOAD;
        loaded_nxt = '0;
        step_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      loaded_r <= '0;
      step_r   <= '0;
      valid_r  <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      step_r   <= step_nxt;
      valid_r  <= valid_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    index_r <= index_nxt;
  end

  assign busy      = (state_r != ST_LOAD);
  assign pivot_k   = step_r;
  assign out_valid = valid_r;
  assign out_index = index_r;
  assign out_last  = last_r;

  a_valid_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $past(state_r == ST_DRAIN))
    else $error("result beat outside drain");

  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    last_r |-> valid_r && (state_r == ST_LOAD))
    else $error("last beat without return to load");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> ({1'b0, step_r} < (IW+1)'(n_act)))
    else $error("pivot step beyond node count");

  a_load_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (loaded_r < n_act))
    else $error("row count reached node count while loading");

endmodule
`default_nettype wire

// File: sv/transitive_closure_bitset_unit.sv
// Top level of the transitive closure bitset unit: cell chain and output registers.
//
// Use: write node_count on cfg_* (valid/ready) while the block is idle and
// start is low; a row beat on start takes precedence over a write.
// Load a matrix by pulsing start with in_row_bits, one row per beat, while
// busy is low; bits at or above node_count are dropped. Rows shift into a
// chain of cells, one row per cell.
// After the n-th row busy rises. The closure runs n pivot steps, one per
// cycle: the chain rotates once per cycle so the pivot row sits in the head
// cell and every cell ORs it in when its own pivot bit is set.
// The chain then rotates out from the head: n result beats, one per cycle,
// flagged by out_valid for one cycle each, with out_row_index counting up
// and out_last_row on the final one. The first beat is registered from the
// head cell in the drain state, right after the last pivot step.
// busy falls with the last result beat, when the next load may begin.
// The receiver cannot stall; results are not held.
// Reset (rst_n low, synchronous) sets node_count to MAX_NODES and
// clears the row count; the row cells need no reset.
`default_nettype none
module transitive_closure_bitset_unit
  import tcb_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [ROW_W-1:0] in_row_bits,
  output logic                  out_valid,
  output logic [ROW_W-1:0]      out_reach_bits,
  output logic [IDX_W-1:0]      out_row_index,
  output logic                  out_last_row,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [NC_W-1:0]  cfg_node_count
);

  localparam int RW = MAX_NODES;
  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  logic [CW-1:0]   n_act_r;
  logic [CW-1:0]   n_act_nxt;
  logic [RW-1:0]   mask_r;
  logic [RW-1:0]   mask_nxt;
  logic            cfg_we;
  tcb_ctl_t        ctl;
  logic [IW-1:0]   pivot_k;
  logic [RW-1:0]   rows [MAX_NODES];
  logic [RW-1:0]   feeds [MAX_NODES];
  logic [RW-1:0]   tail_src;
  logic [ROW_W-1:0] reach_r;

  assign cfg_ready = !busy && !start;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_node_count == '0) begin
      n_act_nxt = CW'(1);
    end else if ({1'b0, cfg_node_count} > (NC_W+1)'(MAX_NODES)) begin
      n_act_nxt = CW'(MAX_NODES);
    end else begin
      n_act_nxt = CW'(cfg_node_count);
    end
    for (int c = 0; c < RW; c++) begin
      mask_nxt[c] = (CW'(c) < n_act_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_act_r <= CW'(MAX_NODES);
      mask_r  <= '1;
    end else if (cfg_we) begin
      n_act_r <= n_act_nxt;
      mask_r  <= mask_nxt;
    end
  end

  tcb_ctrl #(
    .CW (CW),
    .IW (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_we    (cfg_we),
    .n_act     (n_act_r),
    .busy      (busy),
    .ctl       (ctl),
    .pivot_k   (pivot_k),
    .out_valid (out_valid),
    .out_index (out_row_index),
    .out_last  (out_last_row)
  );

  assign tail_src = ctl.load ? (in_row_bits[RW-1:0] & mask_r) : rows[0];

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    if (i == MAX_NODES - 1) begin : g_end
      assign feeds[i] = tail_src;
    end else begin : g_mid
      assign feeds[i] = (CW'(i + 1) == n_act_r) ? tail_src : rows[i+1];
    end

    tcb_cell #(
      .RW (RW),
      .IW (IW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .pivot_k  (pivot_k),
      .head_row (rows[0]),
      .feed_row (feeds[i]),
      .row      (rows[i])
    );
  end

  always_ff @(posedge clk) begin
    if (ctl.shift && !ctl.load) begin
      reach_r <= ROW_W'(rows[0]);
    end
  end

  assign out_reach_bits = reach_r;

endmodule
`default_nettype wire
